// File: hw/rtl/lpq_pkg.sv
// ----------------------------------------------------------------------------
// lpq_pkg: shared types and constants of the packet ring queue
// Sizes, request and status codes, command and configuration structs and
// the ring position helpers.
// ----------------------------------------------------------------------------
package lpq_pkg;

   localparam int RING_BYTES = 4096;
   localparam int MAX_PACKET = 64;
   localparam int HDR_BYTES  = 4;
   localparam int SPACE_MIN  = 16;

   localparam int POS_W    = $clog2(RING_BYTES);
   localparam int SPACE_W  = 13;
   localparam int MBL_W    = 7;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = $clog2(MAX_PACKET);
   localparam int BYTES_W  = 13;
   localparam int PKTS_W   = 11;
   localparam int TOTAL_W  = 7;
   localparam int STATUS_W = 3;
   localparam int SPAN_W   = (POS_W + 1 > SPACE_W) ? POS_W + 1 : SPACE_W;

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SPACE_SIZE    = 1'b0;
   localparam logic REG_MAX_BLOCK_LEN = 1'b1;

   // request codes on the input channel
   localparam logic [1:0] REQ_PUSH  = 2'd0;
   localparam logic [1:0] REQ_POP   = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_NOP   = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_LIMIT = 3'd4;

   // command kinds after classification in the front end
   localparam logic [2:0] KIND_PUSH      = 3'd0;
   localparam logic [2:0] KIND_POP       = 3'd1;
   localparam logic [2:0] KIND_BAD_LIMIT = 3'd2;
   localparam logic [2:0] KIND_CLEAR     = 3'd3;
   localparam logic [2:0] KIND_NOP       = 3'd4;

   typedef struct packed {
      logic [2:0]        kind;
      logic [BYTE_W-1:0] pkt_len;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] read_limit;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmdq_type;

   typedef struct packed {
      logic [SPACE_W-1:0] space_size;
      logic [MBL_W-1:0]   max_block_len;
   } cfg_type;

   // advance a ring position, wrapping at the configured size
   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0]   pos,
                                                 input logic [SPACE_W-1:0] space);
      logic [SPAN_W-1:0] inc;
      inc = SPAN_W'(pos) + SPAN_W'(1);
      return (inc >= SPAN_W'(space)) ? '0 : POS_W'(inc);
   endfunction

   function automatic logic [SPACE_W-1:0] clamp_space(input logic [SPACE_W-1:0] v);
      logic [SPACE_W-1:0] r;
      r = v;
      if (32'(v) < 32'(SPACE_MIN)) r = SPACE_W'(SPACE_MIN);
      else if (32'(v) > 32'(RING_BYTES)) r = SPACE_W'(RING_BYTES);
      return r;
   endfunction

endpackage

// File: hw/rtl/lpq_req_if.sv
// ----------------------------------------------------------------------------
// lpq_req_if: request channel
// Valid/ready channel carrying one push, pop or clear request per beat.
// ----------------------------------------------------------------------------
interface lpq_req_if;
   import lpq_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [BYTE_W-1:0] pkt_len;
   logic [BYTE_W-1:0] data_byte;
   logic [BYTE_W-1:0] read_limit;

   modport source (output valid, req_type, pkt_len, data_byte, read_limit,
                   input  ready);
   modport sink   (input  valid, req_type, pkt_len, data_byte, read_limit,
                   output ready);
endinterface

// File: hw/rtl/lpq_rsp_if.sv
// ----------------------------------------------------------------------------
// lpq_rsp_if: result channel
// Valid/ready channel carrying one result beat: status, popped byte, counts.
// ----------------------------------------------------------------------------
interface lpq_rsp_if;
   import lpq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                byte_valid;
   logic [BYTE_W-1:0]   out_byte;
   logic                last;
   logic [LEN_W-1:0]    full_len;
   logic [PKTS_W-1:0]   pkg_count;
   logic [BYTES_W-1:0]  used_bytes;

   modport source (output valid, status, byte_valid, out_byte, last, full_len,
                          pkg_count, used_bytes,
                   input  ready);
   modport sink   (input  valid, status, byte_valid, out_byte, last, full_len,
                          pkg_count, used_bytes,
                   output ready);
endinterface

// File: hw/rtl/lpq_ram.sv
// ----------------------------------------------------------------------------
// lpq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module lpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/lpq_front.sv
// ----------------------------------------------------------------------------
// lpq_front: request intake
// Accepts request beats, classifies them into commands and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module lpq_front (
   input  logic             clock,
   input  logic             reset,
   lpq_req_if.sink          req_bus,
   input  logic             cmd_pop,
   output lpq_pkg::cmdq_type cmdq
);
   import lpq_pkg::*;

   cmd_type              q_mem_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_AW:0]     count_ff, count_in;
   cmd_type              new_cmd;
   logic                 do_push;
   logic                 do_pop;

   always_comb begin
      new_cmd.pkt_len    = req_bus.pkt_len;
      new_cmd.data_byte  = req_bus.data_byte;
      new_cmd.read_limit = req_bus.read_limit;
      unique case (req_bus.req_type)
         REQ_PUSH:  new_cmd.kind = KIND_PUSH;
         REQ_POP:   new_cmd.kind = (req_bus.read_limit == '0) ? KIND_BAD_LIMIT : KIND_POP;
         REQ_CLEAR: new_cmd.kind = KIND_CLEAR;
         default:   new_cmd.kind = KIND_NOP;
      endcase
   end

   assign req_bus.ready = (count_ff != (CMDQ_AW+1)'(CMDQ_DEPTH));
   assign do_push       = req_bus.valid && req_bus.ready;
   assign do_pop        = cmd_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_mem_ff[wr_ptr_ff] <= new_cmd;
   end

   assign cmdq.valid = (count_ff != '0);
   assign cmdq.cmd   = q_mem_ff[rd_ptr_ff];
endmodule

// File: hw/rtl/lpq_back.sv
// ----------------------------------------------------------------------------
// lpq_back: command execution
// Runs queued commands against the byte ring: header and payload writes,
// header decode and payload streaming on pop, clear. Owns the result
// output register.
// ----------------------------------------------------------------------------
module lpq_back (
   input  logic              clock,
   input  logic              reset,
   input  lpq_pkg::cfg_type  cfg,
   input  lpq_pkg::cmdq_type cmdq,
   output logic              cmd_pop,
   lpq_rsp_if.source         rsp_bus
);
   import lpq_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_PUSH_WR  = 3'd1;
   localparam logic [2:0] S_POP_RD   = 3'd2;
   localparam logic [2:0] S_POP_DATA = 3'd3;
   localparam logic [2:0] S_POP_SKIP = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                byte_valid;
      logic [BYTE_W-1:0]   out_byte;
      logic                last;
      logic [LEN_W-1:0]    full_len;
      logic [PKTS_W-1:0]   pkg_count;
      logic [BYTES_W-1:0]  used_bytes;
   } rsp_type;

   logic [2:0]         state_ff, state_in;
   logic [POS_W-1:0]   head_ff, head_in;
   logic [POS_W-1:0]   tail_ff, tail_in;
   logic [BYTES_W-1:0] held_bytes_ff, held_bytes_in;
   logic [PKTS_W-1:0]  held_pkts_ff, held_pkts_in;
   logic [BYTE_W-1:0]  push_left_ff, push_left_in;
   logic               push_drop_ff, push_drop_in;
   logic [TOTAL_W-1:0] push_total_ff, push_total_in;

   cmd_type            cmd_ff, cmd_in;
   logic [2:0]         wcnt_ff, wcnt_in;
   logic               hdr_ff, hdr_in;
   logic [1:0]         hcnt_ff, hcnt_in;
   logic [BYTE_W-1:0]  hb0_ff, hb0_in;
   logic               hhi_ff, hhi_in;
   logic [LEN_W-1:0]   plen_ff, plen_in;
   logic [LEN_W-1:0]   nout_ff, nout_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               out_free;
   logic               emit;
   rsp_type            emit_data;

   logic               ram_we;
   logic [BYTE_W-1:0]  ram_wdata;
   logic               ram_re;
   logic [BYTE_W-1:0]  ram_rdata;

   // first-byte checks of a push
   logic [MBL_W-1:0]   len_lim;
   logic               len_bad;
   logic [BYTES_W:0]   need_bytes;
   logic               space_bad;

   // header decode
   logic               hdr_hi;
   logic [BYTE_W-1:0]  hdr_sub;
   logic [LEN_W-1:0]   plen_calc;
   logic [LEN_W-1:0]   nout_calc;
   logic [TOTAL_W-1:0] consumed;
   logic [LEN_W:0]     idx_next;

   lpq_ram #(.WIDTH(BYTE_W), .DEPTH(RING_BYTES)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      len_lim    = (cfg.max_block_len < MBL_W'(MAX_PACKET)) ? cfg.max_block_len
                                                           : MBL_W'(MAX_PACKET);
      len_bad    = (cmdq.cmd.pkt_len == '0) ||
                   (cmdq.cmd.pkt_len >= BYTE_W'(len_lim));
      need_bytes = (BYTES_W+1)'(held_bytes_ff) + (BYTES_W+1)'(cmdq.cmd.pkt_len) +
                   (BYTES_W+1)'(HDR_BYTES);
      space_bad  = need_bytes > (BYTES_W+1)'(cfg.space_size);
   end

   // header length: any nonzero upper byte saturates
   always_comb begin
      hdr_hi  = hhi_ff || (ram_rdata != '0);
      hdr_sub = hb0_ff - BYTE_W'(HDR_BYTES);
      if (hdr_hi) plen_calc = LEN_W'(MAX_PACKET - 1);
      else if (hb0_ff < BYTE_W'(HDR_BYTES)) plen_calc = '0;
      else if (hdr_sub > BYTE_W'(MAX_PACKET - 1)) plen_calc = LEN_W'(MAX_PACKET - 1);
      else plen_calc = hdr_sub[LEN_W-1:0];
      nout_calc = (BYTE_W'(plen_calc) < cmd_ff.read_limit) ? plen_calc
                                                          : cmd_ff.read_limit[LEN_W-1:0];
      consumed  = TOTAL_W'(plen_calc) + TOTAL_W'(HDR_BYTES);
      idx_next  = (LEN_W+1)'(idx_ff) + 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      held_bytes_in = held_bytes_ff;
      held_pkts_in  = held_pkts_ff;
      push_left_in  = push_left_ff;
      push_drop_in  = push_drop_ff;
      push_total_in = push_total_ff;
      cmd_in        = cmd_ff;
      wcnt_in       = wcnt_ff;
      hdr_in        = hdr_ff;
      hcnt_in       = hcnt_ff;
      hb0_in        = hb0_ff;
      hhi_in        = hhi_ff;
      plen_in       = plen_ff;
      nout_in       = nout_ff;
      idx_in        = idx_ff;
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      emit          = 1'b0;
      emit_data     = '0;
      emit_data.last = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (cmdq.valid && out_free) begin
               cmd_pop = 1'b1;
               cmd_in  = cmdq.cmd;
               unique case (cmdq.cmd.kind)
                  KIND_PUSH: begin
                     if (push_left_ff != '0) begin
                        // continuation byte of a packet in flight
                        push_left_in = push_left_ff - 1'b1;
                        emit         = 1'b1;
                        if (push_drop_ff) begin
                           if (push_left_ff == BYTE_W'(1)) push_drop_in = 1'b0;
                        end else begin
                           ram_we    = 1'b1;
                           ram_wdata = cmdq.cmd.data_byte;
                           tail_in   = next_pos(tail_ff, cfg.space_size);
                           if (push_left_ff == BYTE_W'(1)) begin
                              held_pkts_in  = held_pkts_ff + 1'b1;
                              held_bytes_in = held_bytes_ff + BYTES_W'(push_total_ff) +
                                              BYTES_W'(HDR_BYTES);
                           end
                        end
                     end else if (len_bad || space_bad) begin
                        emit             = 1'b1;
                        emit_data.status = len_bad ? ST_BAD_LEN : ST_FULL;
                        push_left_in     = (cmdq.cmd.pkt_len != '0) ?
                                           cmdq.cmd.pkt_len - 1'b1 : '0;
                        push_drop_in     = (cmdq.cmd.pkt_len > BYTE_W'(1));
                     end else begin
                        // low header byte now, three zero bytes and payload next
                        ram_we        = 1'b1;
                        ram_wdata     = cmdq.cmd.pkt_len + BYTE_W'(HDR_BYTES);
                        tail_in       = next_pos(tail_ff, cfg.space_size);
                        push_total_in = TOTAL_W'(cmdq.cmd.pkt_len);
                        push_left_in  = cmdq.cmd.pkt_len - 1'b1;
                        push_drop_in  = 1'b0;
                        wcnt_in       = 3'd1;
                        state_in      = S_PUSH_WR;
                     end
                  end
                  KIND_POP: begin
                     if (held_pkts_ff == '0 || held_bytes_ff == '0) begin
                        emit             = 1'b1;
                        emit_data.status = ST_EMPTY;
                     end else begin
                        hdr_in   = 1'b1;
                        hcnt_in  = '0;
                        hhi_in   = 1'b0;
                        state_in = S_POP_RD;
                     end
                  end
                  KIND_BAD_LIMIT: begin
                     emit             = 1'b1;
                     emit_data.status = ST_BAD_LIMIT;
                  end
                  KIND_CLEAR: begin
                     head_in       = '0;
                     tail_in       = '0;
                     held_bytes_in = '0;
                     held_pkts_in  = '0;
                     if (push_left_ff != '0) push_drop_in = 1'b1;
                     emit          = 1'b1;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end

         S_PUSH_WR: begin
            ram_we    = 1'b1;
            ram_wdata = (wcnt_ff == 3'd4) ? cmd_ff.data_byte : '0;
            tail_in   = next_pos(tail_ff, cfg.space_size);
            wcnt_in   = wcnt_ff + 1'b1;
            if (wcnt_ff == 3'd4) begin
               if (push_left_ff == '0) begin
                  held_pkts_in  = held_pkts_ff + 1'b1;
                  held_bytes_in = held_bytes_ff + BYTES_W'(push_total_ff) +
                                  BYTES_W'(HDR_BYTES);
               end
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_POP_RD: begin
            ram_re   = 1'b1;
            head_in  = next_pos(head_ff, cfg.space_size);
            state_in = S_POP_DATA;
         end

         S_POP_DATA: begin
            if (hdr_ff) begin
               if (hcnt_ff == 2'd0) hb0_in = ram_rdata;
               else hhi_in = hhi_ff || (ram_rdata != '0);
               hcnt_in  = hcnt_ff + 1'b1;
               state_in = S_POP_RD;
               if (hcnt_ff == 2'd3) begin
                  hdr_in        = 1'b0;
                  plen_in       = plen_calc;
                  nout_in       = nout_calc;
                  idx_in        = '0;
                  held_bytes_in = (held_bytes_ff > BYTES_W'(consumed)) ?
                                  held_bytes_ff - BYTES_W'(consumed) : '0;
                  held_pkts_in  = held_pkts_ff - 1'b1;
                  if (plen_calc == '0) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            end else if (out_free) begin
               emit                 = 1'b1;
               emit_data.byte_valid = 1'b1;
               emit_data.out_byte   = ram_rdata;
               emit_data.last       = (idx_next == (LEN_W+1)'(nout_ff));
               emit_data.full_len   = emit_data.last ? plen_ff : '0;
               idx_in               = idx_next[LEN_W-1:0];
               if (idx_next == (LEN_W+1)'(plen_ff)) state_in = S_IDLE;
               else if (idx_next < (LEN_W+1)'(nout_ff)) state_in = S_POP_RD;
               else state_in = S_POP_SKIP;
            end
         end

         S_POP_SKIP: begin
            // payload past the read limit is consumed without a read
            head_in = next_pos(head_ff, cfg.space_size);
            idx_in  = idx_next[LEN_W-1:0];
            if (idx_next == (LEN_W+1)'(plen_ff)) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      emit_data.pkg_count  = held_pkts_in;
      emit_data.used_bytes = held_bytes_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         held_bytes_ff <= '0;
         held_pkts_ff  <= '0;
         push_left_ff  <= '0;
         push_drop_ff  <= 1'b0;
         push_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         held_bytes_ff <= held_bytes_in;
         held_pkts_ff  <= held_pkts_in;
         push_left_ff  <= push_left_in;
         push_drop_ff  <= push_drop_in;
         push_total_ff <= push_total_in;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      wcnt_ff <= wcnt_in;
      hdr_ff  <= hdr_in;
      hcnt_ff <= hcnt_in;
      hb0_ff  <= hb0_in;
      hhi_ff  <= hhi_in;
      plen_ff <= plen_in;
      nout_ff <= nout_in;
      idx_ff  <= idx_in;
      if (emit) rsp_data_ff <= emit_data;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_data_ff.status;
   assign rsp_bus.byte_valid = rsp_data_ff.byte_valid;
   assign rsp_bus.out_byte   = rsp_data_ff.out_byte;
   assign rsp_bus.last       = rsp_data_ff.last;
   assign rsp_bus.full_len   = rsp_data_ff.full_len;
   assign rsp_bus.pkg_count  = rsp_data_ff.pkg_count;
   assign rsp_bus.used_bytes = rsp_data_ff.used_bytes;

`ifndef SYNTHESIS
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result beat produced while output register is held");
   a_ram_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("ring written and read in the same cycle");
   a_pop_in_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == S_IDLE))
      else $error("command taken while another is running");
   a_wr_not_dropping: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH_WR) |-> !push_drop_ff)
      else $error("header write on a dropped packet");
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP_DATA && !hdr_ff) |-> (idx_ff < nout_ff))
      else $error("payload beat past the read limit");
`endif
endmodule

// File: hw/rtl/length_prefixed_packet_ring_queue_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring_queue_unit: packet ring queue top level
// Byte ring of length-prefixed packets with an APB-style register port.
// ----------------------------------------------------------------------------
// Requests enter a two-beat command queue and are run one at a time against
// a single-port-per-direction byte RAM, so cost per request is set by RAM
// accesses: a push continuation byte takes at most one write, and a clear,
// no-op or rejected request takes none; the first byte of an accepted packet
// takes five writes (four header bytes and the payload byte); a pop that
// finds a packet takes the command, reads the header (read issue plus
// registered read data per byte), reads each delivered byte the same way and
// steps past each byte skipped past read_limit without a read. Delivery and
// intake stall while the result side holds ready low. Results leave through
// one output register; a request is taken only once it is free or draining.
// No clearing pass runs after reset; the ring is only defined where written.
module length_prefixed_packet_ring_queue_unit (
   input  logic                             clock,
   input  logic                             reset,
   lpq_req_if.sink                          req_bus,
   lpq_rsp_if.source                        rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lpq_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lpq_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lpq_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import lpq_pkg::*;

   logic [SPACE_W-1:0] space_size_ff, space_size_in;
   logic [MBL_W-1:0]   max_block_len_ff, max_block_len_in;
   logic               csr_write;
   logic               reg_sel;
   cfg_type            cfg;
   cmdq_type           cmdq;
   logic               cmd_pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_sel   = paddr[2];

   always_comb begin
      space_size_in    = space_size_ff;
      max_block_len_in = max_block_len_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_SPACE_SIZE:    space_size_in    = clamp_space(pwdata[SPACE_W-1:0]);
            REG_MAX_BLOCK_LEN: max_block_len_in = pwdata[MBL_W-1:0];
            default:           space_size_in    = space_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         space_size_ff    <= clamp_space(SPACE_W'(RING_BYTES));
         max_block_len_ff <= MBL_W'(MAX_PACKET);
      end else begin
         space_size_ff    <= space_size_in;
         max_block_len_ff <= max_block_len_in;
      end
   end

   assign prdata = (reg_sel == REG_MAX_BLOCK_LEN) ? CSR_DATA_W'(max_block_len_ff)
                                                  : CSR_DATA_W'(space_size_ff);

   assign cfg.space_size    = space_size_ff;
   assign cfg.max_block_len = max_block_len_ff;

   lpq_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .cmd_pop (cmd_pop),
      .cmdq    (cmdq)
   );

   lpq_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .cmdq    (cmdq),
      .cmd_pop (cmd_pop),
      .rsp_bus (rsp_bus)
   );
endmodule
